/* sv/ptld_pkg.sv */
`default_nettype none

package ptld_pkg;

  typedef enum logic [2:0] {
    PH_LEADER  = 3'd0,
    PH_FIRST   = 3'd1,
    PH_ADDR_LO = 3'd2,
    PH_DATA_HI = 3'd3,
    PH_DATA_LO = 3'd4,
    PH_DONE    = 3'd5,
    PH_NEXT    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CMD_ADDR    = 2'd0,
    CMD_DEPOSIT = 2'd1,
    CMD_FIELD   = 2'd2,
    CMD_START   = 2'd3
  } command_t;

  typedef enum logic {
    FMT_RIM = 1'b0,
    FMT_BIN = 1'b1
  } tape_format_t;

  localparam logic [7:0]  LEADER_BYTE    = 8'h80;
  localparam logic [12:0] NO_ADDRESS     = 13'h1fff;
  localparam int          ORIGIN_BIT     = 6;
  localparam int          TRAIL_BIT      = 7;

  typedef struct packed {
    phase_t      phase;
    logic [5:0]  held_high_half;
    logic        start_pending;
    logic [12:0] expected_address;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    command_t   command;
    logic [5:0] upper_six;
    logic [5:0] lower_six;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:            PH_LEADER,
    held_high_half:   6'd0,
    start_pending:    1'b0,
    expected_address: NO_ADDRESS
  };

endpackage

`default_nettype wire

/* sv/ptld_frame_decode.sv */
`default_nettype none

module ptld_frame_decode (
  input  wire ptld_pkg::tape_format_t tape_format,
  input  wire ptld_pkg::parse_state_t state,
  input  wire logic [7:0]             tape_byte,
  output ptld_pkg::parse_state_t      state_next,
  output ptld_pkg::result_t           result
);

  logic [5:0]  low_bits;
  logic [11:0] address;
  logic        is_field;
  logic        is_origin;
  logic        is_trail;
  logic        is_leader;

  assign low_bits  = tape_byte[5:0];
  assign address   = {state.held_high_half, low_bits};
  assign is_field  = tape_byte[ptld_pkg::TRAIL_BIT] & tape_byte[ptld_pkg::ORIGIN_BIT];
  assign is_origin = tape_byte[ptld_pkg::ORIGIN_BIT];
  assign is_trail  = tape_byte[ptld_pkg::TRAIL_BIT];
  assign is_leader = (tape_byte == ptld_pkg::LEADER_BYTE);

  // next state
  always_comb begin
    state_next = state;
    if (tape_format == ptld_pkg::FMT_RIM) begin
      unique case (state.phase)
        ptld_pkg::PH_LEADER: begin
          if (is_leader) state_next.phase = ptld_pkg::PH_FIRST;
        end
        ptld_pkg::PH_FIRST: begin
          if (is_origin) begin
            state_next.held_high_half = low_bits;
            state_next.phase          = ptld_pkg::PH_ADDR_LO;
          end
        end
        ptld_pkg::PH_ADDR_LO: begin
          state_next.phase = ptld_pkg::PH_DATA_HI;
          if ({1'b0, address} != state.expected_address) begin
            state_next.expected_address = {1'b0, address};
          end
        end
        ptld_pkg::PH_DATA_HI: begin
          state_next.held_high_half = low_bits;
          state_next.phase          = ptld_pkg::PH_DATA_LO;
        end
        ptld_pkg::PH_DATA_LO: begin
          state_next.phase            = ptld_pkg::PH_NEXT;
          state_next.expected_address = state.expected_address + 13'd1;
        end
        ptld_pkg::PH_NEXT: begin
          if (is_trail) begin
            state_next.phase = ptld_pkg::PH_DONE;
          end else if (is_origin) begin
            state_next.held_high_half = low_bits;
            state_next.phase          = ptld_pkg::PH_ADDR_LO;
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (state.phase)
        ptld_pkg::PH_LEADER: begin
          if (is_leader) state_next.phase = ptld_pkg::PH_FIRST;
          state_next.start_pending = 1'b0;
        end
        ptld_pkg::PH_FIRST, ptld_pkg::PH_NEXT: begin
          priority if (is_field) begin
            // load field leaves phase and pending start alone
          end else if (is_origin) begin
            state_next.held_high_half = low_bits;
            state_next.phase          = ptld_pkg::PH_ADDR_LO;
            state_next.start_pending  = 1'b1;
          end else if (state.phase == ptld_pkg::PH_FIRST && is_leader) begin
            // repeated leader
          end else if (state.phase == ptld_pkg::PH_NEXT && is_trail) begin
            state_next.phase         = ptld_pkg::PH_DONE;
            state_next.start_pending = 1'b0;
          end else begin
            state_next.held_high_half = low_bits;
            state_next.phase          = ptld_pkg::PH_DATA_HI;
            state_next.start_pending  = 1'b0;
          end
        end
        ptld_pkg::PH_ADDR_LO, ptld_pkg::PH_DATA_HI: begin
          state_next.phase = ptld_pkg::PH_NEXT;
        end
        default: begin
        end
      endcase
    end
  end

  // result word
  always_comb begin
    result.valid     = 1'b0;
    result.command   = ptld_pkg::CMD_ADDR;
    result.upper_six = state.held_high_half;
    result.lower_six = low_bits;
    if (tape_format == ptld_pkg::FMT_RIM) begin
      unique case (state.phase)
        ptld_pkg::PH_ADDR_LO: begin
          result.valid   = ({1'b0, address} != state.expected_address);
          result.command = ptld_pkg::CMD_ADDR;
        end
        ptld_pkg::PH_DATA_LO: begin
          result.valid   = 1'b1;
          result.command = ptld_pkg::CMD_DEPOSIT;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (state.phase)
        ptld_pkg::PH_FIRST, ptld_pkg::PH_NEXT: begin
          priority if (is_field) begin
            result.valid     = 1'b1;
            result.command   = ptld_pkg::CMD_FIELD;
            result.upper_six = low_bits;
            result.lower_six = 6'd0;
          end else if (!is_origin && state.phase == ptld_pkg::PH_NEXT && is_trail) begin
            result.valid     = state.start_pending;
            result.command   = ptld_pkg::CMD_START;
            result.upper_six = 6'd0;
            result.lower_six = 6'd0;
          end else begin
          end
        end
        ptld_pkg::PH_ADDR_LO: begin
          result.valid   = 1'b1;
          result.command = ptld_pkg::CMD_ADDR;
        end
        ptld_pkg::PH_DATA_HI: begin
          result.valid   = 1'b1;
          result.command = ptld_pkg::CMD_DEPOSIT;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/paper_tape_loader_decoder_core.sv */
// Paper tape loader decoder: takes one tape byte per word on the input channel and
// gives at most one loader command per byte (load address, deposit word, load field,
// start) on the output channel. tape_format selects RIM (0) or BIN (1); any write to
// it restarts parsing from the leader search, and should be made only while the block
// is idle. A byte is taken every cycle unless the command channel stalls; it waits in
// the input register, and its command, if any, is written to the result register when
// the byte is decoded, which happens once the result register is free or being taken.
// The parse state is updated once per byte. The BIN checksum is not checked; it comes
// out as an ordinary deposit.
`default_nettype none

module paper_tape_loader_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       tape_format_we,
  input  wire logic       tape_format_wdata,
  // tape byte channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] tape_byte,
  // command channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      command,
  output logic [5:0]      upper_six,
  output logic [5:0]      lower_six
);

  ptld_pkg::tape_format_t tape_format;
  ptld_pkg::parse_state_t state;
  ptld_pkg::parse_state_t state_next;
  ptld_pkg::result_t      result;

  // input register
  logic       byte_full;
  logic [7:0] byte_held;

  // decode fires when a byte is held and the result register is free or draining
  logic fire;

  assign fire     = byte_full && (!out_valid || out_ready);
  assign in_ready = !byte_full || fire;

  ptld_frame_decode u_decode (
    .tape_format (tape_format),
    .state       (state),
    .tape_byte   (byte_held),
    .state_next  (state_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_full <= 1'b1;
    end else if (fire) begin
      byte_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_held <= tape_byte;
    end
  end

  // format register and parse state; a format write restarts the grammar
  always_ff @(posedge clk) begin
    if (rst) begin
      tape_format <= ptld_pkg::FMT_RIM;
      state       <= ptld_pkg::STATE_RESET;
    end else if (tape_format_we) begin
      tape_format <= ptld_pkg::tape_format_t'(tape_format_wdata);
      state       <= ptld_pkg::STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.valid) begin
      command   <= result.command;
      upper_six <= result.upper_six;
      lower_six <= result.lower_six;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ptld_pkg::*;

  // run shape
  localparam int RANDOM_BYTES  = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 500;
  localparam int STALL_LIMIT   = 1000;  // cycles with no word moving on either side
  localparam int N_DIRECTED    = 25;

  // both control bits set marks a field frame
  localparam logic [7:0] FIELD_MASK = 8'hC0;

  typedef struct packed {
    command_t   cmd;
    logic [5:0] upper;
    logic [5:0] lower;
  } loader_cmd_t;

  // how a directed row is handled: a register write, a byte known to give nothing,
  // a byte with its command typed in, or a byte left to the decoder model
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_QUIET,
    ROW_TYPED,
    ROW_MODEL
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  val;
    loader_cmd_t want;
  } stim_row_t;

  localparam loader_cmd_t NO_CMD = '{CMD_ADDR, 6'd0, 6'd0};

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // rim straight after reset
    '{ROW_QUIET, 8'hC0, NO_CMD},                          // not exactly leader
    '{ROW_QUIET, 8'h80, NO_CMD},                          // leader
    '{ROW_QUIET, 8'h3F, NO_CMD},                          // no origin bit, eaten
    '{ROW_QUIET, 8'h7F, NO_CMD},                          // origin, high half all ones
    '{ROW_TYPED, 8'h3F, '{CMD_ADDR, 6'h3F, 6'h3F}},       // top address
    '{ROW_QUIET, 8'h00, NO_CMD},
    '{ROW_TYPED, 8'hFF, '{CMD_DEPOSIT, 6'h00, 6'h3F}},    // next address wraps past 12 bits
    '{ROW_QUIET, 8'h40, NO_CMD},
    '{ROW_TYPED, 8'h00, '{CMD_ADDR, 6'h00, 6'h00}},       // address zero after the wrap
    '{ROW_QUIET, 8'h15, NO_CMD},
    '{ROW_MODEL, 8'h2A, NO_CMD},
    '{ROW_QUIET, 8'h40, NO_CMD},
    '{ROW_QUIET, 8'h01, NO_CMD},                          // sequential, load left out
    '{ROW_QUIET, 8'h3F, NO_CMD},
    '{ROW_TYPED, 8'h00, '{CMD_DEPOSIT, 6'h3F, 6'h00}},
    '{ROW_QUIET, 8'h80, NO_CMD},                          // trailer, tape done
    '{ROW_QUIET, 8'h41, NO_CMD},                          // ignored once done
    // bin
    '{ROW_CFG,   8'h01, NO_CMD},
    '{ROW_QUIET, 8'h80, NO_CMD},
    '{ROW_QUIET, 8'h80, NO_CMD},                          // repeated leader skipped
    '{ROW_TYPED, 8'hC5, '{CMD_FIELD, 6'h05, 6'h00}},      // field frame
    '{ROW_QUIET, 8'h41, NO_CMD},                          // origin
    '{ROW_TYPED, 8'h3E, '{CMD_ADDR, 6'h01, 6'h3E}},
    '{ROW_TYPED, 8'h80, '{CMD_START, 6'h00, 6'h00}},      // trailer straight after origin
    '{ROW_QUIET, 8'h00, NO_CMD}                           // ignored once done
  };

  // dut ports; the inputs are all known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       tape_format_we = 1'b0;
  logic       tape_format_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] tape_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] command;
  logic [5:0] upper_six;
  logic [5:0] lower_six;

  paper_tape_loader_decoder_core dut (
    .clk               (clk),
    .rst               (rst),
    .tape_format_we    (tape_format_we),
    .tape_format_wdata (tape_format_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .tape_byte         (tape_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .command           (command),
    .upper_six         (upper_six),
    .lower_six         (lower_six)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // decoder model state, kept apart from the block
  tape_format_t fmt_m;
  phase_t       ph_m;
  logic [5:0]   held_m;
  logic         pend_m;
  logic [12:0]  next_addr_m;

  loader_cmd_t  pending_cmds [$];   // commands owed by the block, oldest first
  int           errors = 0;
  int           bytes_taken = 0;
  int           formats_written = 0;
  int           cmd_count [4] = '{0, 0, 0, 0};
  int           burst_left = 0;

  // back to the leader search, as after reset or any format write
  task automatic reset_parser();
    ph_m        = PH_LEADER;
    held_m      = 6'd0;
    pend_m      = 1'b0;
    next_addr_m = NO_ADDRESS;
  endtask

  // one tape byte through the frame grammar; hit says whether a command comes out
  task automatic decode_tape_byte(input logic [7:0] b, output bit hit, output loader_cmd_t c);
    logic [5:0]  lo6;
    logic [12:0] addr;
    lo6 = b[5:0];
    hit = 1'b0;
    c   = NO_CMD;
    if (fmt_m == FMT_RIM) begin
      case (ph_m)
        PH_LEADER: if (b == LEADER_BYTE) ph_m = PH_FIRST;
        PH_FIRST: if (b[ORIGIN_BIT]) begin
          held_m = lo6;
          ph_m   = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          ph_m = PH_DATA_HI;
          addr = {1'b0, held_m, lo6};
          // load address only when not simply the next location
          if (addr != next_addr_m) begin
            next_addr_m = addr;
            hit = 1'b1;
            c   = '{CMD_ADDR, held_m, lo6};
          end
        end
        PH_DATA_HI: begin
          held_m = lo6;
          ph_m   = PH_DATA_LO;
        end
        PH_DATA_LO: begin
          ph_m        = PH_NEXT;
          next_addr_m = next_addr_m + 13'd1;
          hit = 1'b1;
          c   = '{CMD_DEPOSIT, held_m, lo6};
        end
        PH_NEXT: begin
          if (b[TRAIL_BIT]) begin
            ph_m = PH_DONE;
          end else if (b[ORIGIN_BIT]) begin
            held_m = lo6;
            ph_m   = PH_ADDR_LO;
          end
        end
        default: ;
      endcase
    end else begin
      case (ph_m)
        PH_LEADER: begin
          if (b == LEADER_BYTE) ph_m = PH_FIRST;
          pend_m = 1'b0;
        end
        PH_FIRST, PH_NEXT: begin
          if ((b & FIELD_MASK) == FIELD_MASK) begin
            hit = 1'b1;
            c   = '{CMD_FIELD, lo6, 6'd0};
          end else if (b[ORIGIN_BIT]) begin
            held_m = lo6;
            ph_m   = PH_ADDR_LO;
            pend_m = 1'b1;
          end else if (ph_m == PH_FIRST && b == LEADER_BYTE) begin
            // more leader, skipped
          end else if (ph_m == PH_NEXT && b[TRAIL_BIT]) begin
            ph_m = PH_DONE;
            if (pend_m) begin
              pend_m = 1'b0;
              hit = 1'b1;
              c   = '{CMD_START, 6'd0, 6'd0};
            end
          end else begin
            held_m = lo6;
            ph_m   = PH_DATA_HI;
            pend_m = 1'b0;
          end
        end
        PH_ADDR_LO: begin
          ph_m = PH_NEXT;
          hit = 1'b1;
          c   = '{CMD_ADDR, held_m, lo6};
        end
        PH_DATA_HI: begin
          ph_m = PH_NEXT;
          hit = 1'b1;
          c   = '{CMD_DEPOSIT, held_m, lo6};
        end
        default: ;
      endcase
    end
  endtask

  // offer one byte; the sender runs in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b, input row_kind_t kind, input loader_cmd_t want);
    int          gap;
    bit          hit;
    loader_cmd_t c;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 7);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    tape_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_taken++;
    decode_tape_byte(b, hit, c);
    case (kind)
      ROW_MODEL: if (hit) pending_cmds.push_back(c);
      ROW_TYPED: pending_cmds.push_back(want);
      default: ;
    endcase
  endtask

  // stop sending, let every owed command out, then give any quiet byte time to clear
  task automatic drain_results();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_cmds.size() != 0) begin
      $error("%0d expected commands never came out", pending_cmds.size());
      errors += pending_cmds.size();
      pending_cmds.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // format writes only while the block is idle
  task automatic write_format(input logic v);
    drain_results();
    tape_format_we    <= 1'b1;
    tape_format_wdata <= v;
    @(posedge clk);
    tape_format_we <= 1'b0;
    fmt_m = tape_format_t'(v);
    reset_parser();
    formats_written++;
  endtask

  // receiver: a stall pattern that changes each time the 6-bit cycle counter wraps
  logic [5:0] rx_cycle = 6'd0;
  logic [1:0] rx_mode  = 2'd0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 6'd1;
    if (rx_cycle == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready <= 1'b1;                        // never stalls
      2'd1: out_ready <= 1'($urandom_range(0, 1));    // coin toss
      2'd2: out_ready <= (rx_cycle[1:0] == 2'd0);     // ready when the low two counter bits are zero
      default: out_ready <= (rx_cycle[3:0] >= 4'd12); // long stall, short open
    endcase
  end

  // check each command word taken against the oldest one owed
  loader_cmd_t oldest;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected command %0d (%0d, %0d) with nothing owed",
               command, upper_six, lower_six);
        errors++;
      end else begin
        oldest = pending_cmds.pop_front();
        cmd_count[oldest.cmd]++;
        if (command !== oldest.cmd) begin
          $error("command: expected %0d, got %0d", oldest.cmd, command);
          errors++;
        end
        if (upper_six !== oldest.upper) begin
          $error("upper_six: expected %0d, got %0d", oldest.upper, upper_six);
          errors++;
        end
        if (lower_six !== oldest.lower) begin
          $error("lower_six: expected %0d, got %0d", oldest.lower, lower_six);
          errors++;
        end
      end
    end
  end

  // watchdog: ends the run when no word moves on either side for too long
  initial begin
    int stuck;
    stuck = 0;
    wait (rst == 1'b0);
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int         style;
    int         nwords;
    int         nseg;
    int         phase_no;
    logic [11:0] addr;

    fmt_m = FMT_RIM;
    reset_parser();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows first, straight after reset in rim
    for (int k = 0; k < N_DIRECTED; k++) begin
      if (DIRECTED[k].kind == ROW_CFG) write_format(DIRECTED[k].val[0]);
      else send_byte(DIRECTED[k].val, DIRECTED[k].kind, DIRECTED[k].want);
    end

    // random tapes, one per format setting; the first two pin both formats
    phase_no = 0;
    while (bytes_taken < N_DIRECTED + RANDOM_BYTES) begin
      if (phase_no < 2) write_format(phase_no[0]);
      else write_format(1'($urandom_range(0, 1)));
      phase_no++;
      style = $urandom_range(0, 9);

      if (style == 0) begin
        // pure noise
        repeat ($urandom_range(10, 40))
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
      end else if (fmt_m == FMT_RIM) begin
        // a rim tape: leader, address and data frames, trailer, with stray bytes mixed in
        if ($urandom_range(0, 2) == 0)
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
        repeat ($urandom_range(1, 4)) send_byte(LEADER_BYTE, ROW_MODEL, NO_CMD);
        addr   = 12'($urandom_range(0, 4095));
        nwords = $urandom_range(1, 30);
        repeat (nwords) begin
          // mostly sequential, so the address load is often left out
          if ($urandom_range(0, 3) == 0) addr = 12'($urandom_range(0, 4095));
          else addr = addr + 12'd1;
          send_byte({2'b01, addr[11:6]}, ROW_MODEL, NO_CMD);
          send_byte({2'($urandom_range(0, 3)), addr[5:0]}, ROW_MODEL, NO_CMD);
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
          if ($urandom_range(0, 19) == 0)
            send_byte({2'b00, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
          if ($urandom_range(0, 39) == 0)
            send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
        end
        send_byte({1'b1, 7'($urandom_range(0, 127))}, ROW_MODEL, NO_CMD);
        repeat ($urandom_range(0, 3))
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
      end else begin
        // a bin tape: leader, segments of field, origin and data, checksum, trailer
        repeat ($urandom_range(1, 4)) send_byte(LEADER_BYTE, ROW_MODEL, NO_CMD);
        nseg = $urandom_range(1, 4);
        repeat (nseg) begin
          if ($urandom_range(0, 2) == 0)
            send_byte({2'b11, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
          send_byte({2'b01, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
          nwords = $urandom_range(0, 10);
          repeat (nwords) begin
            send_byte({2'b00, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
            send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
            if ($urandom_range(0, 39) == 0)
              send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
          end
        end
        // checksum goes in as a plain data word
        send_byte({2'b00, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
        send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
        // ending on an origin asks for a start on the trailer
        if ($urandom_range(0, 1) == 0) begin
          send_byte({2'b01, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
          if ($urandom_range(0, 2) == 0)
            send_byte({2'b11, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
        end
        send_byte({2'b10, 6'($urandom_range(0, 63))}, ROW_MODEL, NO_CMD);
        repeat ($urandom_range(0, 3))
          send_byte(8'($urandom_range(0, 255)), ROW_MODEL, NO_CMD);
      end
    end

    drain_results();

    $display("%0d tape bytes over %0d format writes; commands checked: %0d load address,",
             bytes_taken, formats_written, cmd_count[CMD_ADDR]);
    $display("%0d deposit, %0d load field, %0d start; %0d mismatches",
             cmd_count[CMD_DEPOSIT], cmd_count[CMD_FIELD], cmd_count[CMD_START], errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
